// ----- sv/cbse_pkg.sv -----
// Shared constants and handshake enable types for the cubic B-spline evaluator.
package cbse_pkg;

   // Register stages inside one split multiplier.
   localparam int MUL_STAGES = 2;

   // Register stages inside one rounding and saturation unit.
   localparam int RND_STAGES = 3;

   // Widest slice of the wide operand that goes into one partial product.
   localparam int MUL_PIECE_MAX = 24;

   // The spline basis carries a common factor of 1/6.
   localparam int DIVISOR = 6;

   // Extra reciprocal bits for an exact divide by the basis divisor.
   localparam int RND_GUARD = 3;

   // Per-stage load enables handed to the pipelined units.
   typedef logic [MUL_STAGES-1:0] mul_en_type;
   typedef logic [RND_STAGES-1:0] rnd_en_type;

endpackage

// ----- sv/cbse_coef.sv -----
// Power-basis coefficient stage: turns four control samples into scaled cubic coefficients.
module cbse_coef #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_WIDTH   = 16,
   parameter int COEF_WIDTH   = 20
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_0,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_1,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_2,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_3,
   input  logic        [FRAC_WIDTH-1:0]   frac_pos,
   output logic signed [COEF_WIDTH-1:0]   coef_3,
   output logic signed [COEF_WIDTH-1:0]   coef_2,
   output logic signed [COEF_WIDTH-1:0]   coef_1,
   output logic signed [COEF_WIDTH-1:0]   coef_0,
   output logic        [FRAC_WIDTH-1:0]   frac
);

   logic signed [COEF_WIDTH-1:0] s0, s1, s2, s3;
   logic signed [COEF_WIDTH-1:0] diff_12, mid_sum, diff_20;
   logic signed [COEF_WIDTH-1:0] coef_3_in, coef_2_in, coef_1_in, coef_0_in;
   logic signed [COEF_WIDTH-1:0] coef_3_ff, coef_2_ff, coef_1_ff, coef_0_ff;
   logic        [FRAC_WIDTH-1:0] frac_ff;

   // Coefficients times six: c3 = -p0+3p1-3p2+p3, c2 = 3p0-6p1+3p2,
   // c1 = -3p0+3p2, c0 = p0+4p1+p2. Multiples by three are shift and add.
   always_comb begin
      s0        = COEF_WIDTH'(sample_0);
      s1        = COEF_WIDTH'(sample_1);
      s2        = COEF_WIDTH'(sample_2);
      s3        = COEF_WIDTH'(sample_3);
      diff_12   = s1 - s2;
      mid_sum   = s0 - (s1 <<< 1) + s2;
      diff_20   = s2 - s0;
      coef_3_in = (s3 - s0) + (diff_12 <<< 1) + diff_12;
      coef_2_in = (mid_sum <<< 1) + mid_sum;
      coef_1_in = (diff_20 <<< 1) + diff_20;
      coef_0_in = s0 + (s1 <<< 2) + s2;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (en) begin
         coef_3_ff <= coef_3_in;
         coef_2_ff <= coef_2_in;
         coef_1_ff <= coef_1_in;
         coef_0_ff <= coef_0_in;
         frac_ff   <= frac_pos;
      end
   end

   assign coef_3 = coef_3_ff;
   assign coef_2 = coef_2_ff;
   assign coef_1 = coef_1_ff;
   assign coef_0 = coef_0_ff;
   assign frac   = frac_ff;

endmodule

// ----- sv/cbse_mul.sv -----
// Two-stage multiplier of a wide signed operand by an unsigned fraction, split into slices.
module cbse_mul
   import cbse_pkg::*;
#(
   parameter int A_WIDTH = 37,
   parameter int B_WIDTH = 16
) (
   input  logic                              clock,
   input  mul_en_type                        en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic        [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

   localparam int P_WIDTH     = A_WIDTH + B_WIDTH;
   localparam int NUM_PIECES  = (A_WIDTH + MUL_PIECE_MAX - 1) / MUL_PIECE_MAX;
   localparam int PIECE_WIDTH = (A_WIDTH + NUM_PIECES - 1) / NUM_PIECES;
   localparam int TOP_WIDTH   = A_WIDTH - (NUM_PIECES - 1) * PIECE_WIDTH;

   wire  signed [P_WIDTH-1:0]           term [NUM_PIECES];
   logic signed [B_WIDTH:0]             b_ext;
   logic signed [TOP_WIDTH+B_WIDTH:0]   top_full;
   logic signed [TOP_WIDTH+B_WIDTH-1:0] top_in, top_ff;
   logic signed [P_WIDTH-1:0]           sum_in, prod_ff;

   assign b_ext = {1'b0, b};

   // Lower slices of the operand are unsigned partial products.
   for (genvar g = 0; g < NUM_PIECES - 1; g++) begin : g_low
      logic [PIECE_WIDTH+B_WIDTH-1:0] pp_in, pp_ff;

      assign pp_in = a[g*PIECE_WIDTH +: PIECE_WIDTH] * b;

      always_ff @(posedge clock) begin
         if (en[0]) begin
            pp_ff <= pp_in;
         end
      end

      assign term[g] = P_WIDTH'(pp_ff) << (g * PIECE_WIDTH);
   end

   // The top slice carries the sign.
   assign top_full = $signed(a[A_WIDTH-1 -: TOP_WIDTH]) * b_ext;
   assign top_in   = top_full[TOP_WIDTH+B_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         top_ff <= top_in;
      end
   end

   assign term[NUM_PIECES-1] = P_WIDTH'(top_ff) <<< ((NUM_PIECES - 1) * PIECE_WIDTH);

   // Second stage: line up and add the partial products.
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_PIECES; i++) begin
         sum_in = sum_in + term[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff <= sum_in;
      end
   end

   assign p = prod_ff;

endmodule

// ----- sv/cbse_round.sv -----
// Three-stage unit that divides by six times a power of two, rounds and saturates.
module cbse_round
   import cbse_pkg::*;
#(
   parameter int NUM_WIDTH = 71,
   parameter int SHIFT     = 48,
   parameter int OUT_WIDTH = 16,
   parameter int MAG_WIDTH = 22
) (
   input  logic                        clock,
   input  rnd_en_type                  en,
   input  logic signed [NUM_WIDTH-1:0] num,
   output logic signed [OUT_WIDTH-1:0] res
);

   localparam int RECIP_SHIFT = MAG_WIDTH + RND_GUARD;
   localparam int PROD_WIDTH  = 2 * MAG_WIDTH + 1;
   localparam int Q_WIDTH     = PROD_WIDTH - RECIP_SHIFT;
   localparam int HALF_DIV    = DIVISOR / 2;
   localparam logic [MAG_WIDTH:0] RECIP =
      (MAG_WIDTH + 1)'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));
   localparam logic [Q_WIDTH-1:0] LIM_POS = Q_WIDTH'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
   localparam logic [Q_WIDTH-1:0] LIM_NEG = Q_WIDTH'(64'd1 << (OUT_WIDTH - 1));
   localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH - 1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH - 1){1'b0}}};

   logic                   neg_in, neg_a_ff, neg_b_ff;
   logic [NUM_WIDTH-1:0]   abs_val;
   logic [NUM_WIDTH:0]     biased, scaled;
   logic [MAG_WIDTH-1:0]   mag_in, mag_ff;
   logic [PROD_WIDTH-1:0]  prod;
   logic [Q_WIDTH-1:0]     quot_in, quot_ff;
   logic [OUT_WIDTH-1:0]   res_in, res_ff;

   // Stage A: magnitude, add half of the divisor in the scaled units, drop the
   // power-of-two part. Ties thus round away from zero.
   always_comb begin
      neg_in  = num[NUM_WIDTH-1];
      abs_val = neg_in ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
      biased  = {1'b0, abs_val} + ((NUM_WIDTH + 1)'(HALF_DIV) << SHIFT);
      scaled  = biased >> SHIFT;
      mag_in  = (|scaled[NUM_WIDTH:MAG_WIDTH]) ? '1 : scaled[MAG_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg_a_ff <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   // Stage B: divide by six through a reciprocal that is exact for this range.
   assign prod    = mag_ff * RECIP;
   assign quot_in = prod[PROD_WIDTH-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         neg_b_ff <= neg_a_ff;
         quot_ff  <= quot_in;
      end
   end

   // Stage C: clamp to the output range and restore the sign.
   always_comb begin
      if (neg_b_ff) begin
         res_in = (quot_ff > LIM_NEG) ? OUT_MIN : -(OUT_WIDTH'(quot_ff));
      end else begin
         res_in = (quot_ff > LIM_POS) ? OUT_MAX : OUT_WIDTH'(quot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- sv/cbse_dly.sv -----
// Stall-aware delay line that carries a word alongside the pipeline stages.
module cbse_dly #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   // Each tap loads from the one before it when its stage advances.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         stage_ff[0] <= d;
      end
      for (int i = 1; i < DEPTH; i++) begin
         if (en[i]) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q = stage_ff[DEPTH-1];

endmodule

// ----- sv/cubic_bspline_eval_jet.sv -----
// Uniform cubic B-spline evaluator: value, slope and curvature from four samples.
// Throughput: one word per cycle while no response stall backs up to the request side;
// the pipeline is a coefficient register, three Horner steps of a two-stage multiply
// and a sum register each, plus a three-stage divide, round and saturate unit.
// Stages advance independently, so bubbles close up under a response stall.
// Reset clears the stage valid bits only; data registers are not reset.
module cubic_bspline_eval_jet
   import cbse_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_WIDTH   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_0,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_1,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_2,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_3,
   input  logic        [FRAC_WIDTH-1:0]   req_frac_pos,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_curve_value,
   output logic signed [SAMPLE_WIDTH:0]   rsp_slope,
   output logic signed [SAMPLE_WIDTH+1:0] rsp_curvature
);

   // Datapath widths; every step below is exact.
   localparam int CW  = SAMPLE_WIDTH + 4;
   localparam int P1W = CW + FRAC_WIDTH;
   localparam int H1W = P1W + 1;
   localparam int G1W = P1W + 3;
   localparam int E2W = P1W + 4;
   localparam int Q1W = H1W + FRAC_WIDTH;
   localparam int R1W = G1W + FRAC_WIDTH;
   localparam int H2W = Q1W + 1;
   localparam int D1W = R1W + 1;
   localparam int Q2W = H2W + FRAC_WIDTH;
   localparam int VW  = Q2W + 1;
   localparam int MW  = SAMPLE_WIDTH + 6;

   // Stage numbers, counted from the coefficient register.
   localparam int ST_COEF = 1;
   localparam int ST_P1   = ST_COEF + MUL_STAGES;
   localparam int ST_ADD1 = ST_P1 + 1;
   localparam int ST_Q1   = ST_ADD1 + MUL_STAGES;
   localparam int ST_ADD2 = ST_Q1 + 1;
   localparam int ST_Q2   = ST_ADD2 + MUL_STAGES;
   localparam int ST_ADD3 = ST_Q2 + 1;
   localparam int ST_D2R  = ST_ADD1 + RND_STAGES;
   localparam int ST_D1R  = ST_ADD2 + RND_STAGES;
   localparam int ST_OUT  = ST_ADD3 + RND_STAGES;

   logic [ST_OUT+1:1] stage_en;
   logic [ST_OUT:1]   vld_ff, vld_in;
   logic              in_acc, out_acc;

   logic signed [CW-1:0]          coef_3_1, coef_2_1, coef_1_1, coef_0_1;
   logic signed [CW-1:0]          coef_2_3, coef_1_6, coef_0_9;
   logic        [FRAC_WIDTH-1:0]  frac_1, frac_4, frac_7;
   logic signed [P1W-1:0]         prod_1;
   logic signed [H1W-1:0]         horner_1_in, horner_1_ff;
   logic signed [G1W-1:0]         slope_1_in, slope_1_ff;
   logic signed [E2W-1:0]         curv_num_in, curv_num_ff;
   logic signed [Q1W-1:0]         prod_2;
   logic signed [R1W-1:0]         slope_prod;
   logic signed [H2W-1:0]         horner_2_in, horner_2_ff;
   logic signed [D1W-1:0]         slope_num_in, slope_num_ff;
   logic signed [Q2W-1:0]         prod_3;
   logic signed [VW-1:0]          value_num_in, value_num_ff;
   logic signed [SAMPLE_WIDTH+1:0] curv_rnd;
   logic signed [SAMPLE_WIDTH:0]   slope_rnd;

   // Stage advance: a stage loads when it is empty or its successor moves.
   assign stage_en[ST_OUT+1] = !rsp_stall;
   for (genvar gi = 1; gi <= ST_OUT; gi++) begin : g_adv
      assign stage_en[gi] = !vld_ff[gi] || stage_en[gi+1];
   end

   // Valid bits travel with the words.
   assign vld_in = {vld_ff[ST_OUT-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= ST_OUT; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !stage_en[1];
   assign rsp_valid = vld_ff[ST_OUT];
   assign in_acc    = req_valid && !req_stall;
   assign out_acc   = rsp_valid && !rsp_stall;

   // Coefficients scaled by six.
   cbse_coef #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_WIDTH   (FRAC_WIDTH),
      .COEF_WIDTH   (CW)
   ) u_coef (
      .clock    (clock),
      .en       (stage_en[ST_COEF]),
      .sample_0 (req_sample_0),
      .sample_1 (req_sample_1),
      .sample_2 (req_sample_2),
      .sample_3 (req_sample_3),
      .frac_pos (req_frac_pos),
      .coef_3   (coef_3_1),
      .coef_2   (coef_2_1),
      .coef_1   (coef_1_1),
      .coef_0   (coef_0_1),
      .frac     (frac_1)
   );

   // Words that wait for their Horner step.
   cbse_dly #(.WIDTH(FRAC_WIDTH), .DEPTH(ST_ADD1 - ST_COEF)) u_dly_frac_a (
      .clock (clock),
      .en    (stage_en[ST_ADD1:ST_COEF+1]),
      .d     (frac_1),
      .q     (frac_4)
   );

   cbse_dly #(.WIDTH(FRAC_WIDTH), .DEPTH(ST_ADD2 - ST_ADD1)) u_dly_frac_b (
      .clock (clock),
      .en    (stage_en[ST_ADD2:ST_ADD1+1]),
      .d     (frac_4),
      .q     (frac_7)
   );

   cbse_dly #(.WIDTH(CW), .DEPTH(ST_P1 - ST_COEF)) u_dly_coef_2 (
      .clock (clock),
      .en    (stage_en[ST_P1:ST_COEF+1]),
      .d     (coef_2_1),
      .q     (coef_2_3)
   );

   cbse_dly #(.WIDTH(CW), .DEPTH(ST_Q1 - ST_COEF)) u_dly_coef_1 (
      .clock (clock),
      .en    (stage_en[ST_Q1:ST_COEF+1]),
      .d     (coef_1_1),
      .q     (coef_1_6)
   );

   cbse_dly #(.WIDTH(CW), .DEPTH(ST_Q2 - ST_COEF)) u_dly_coef_0 (
      .clock (clock),
      .en    (stage_en[ST_Q2:ST_COEF+1]),
      .d     (coef_0_1),
      .q     (coef_0_9)
   );

   // First Horner product c3 * t.
   cbse_mul #(.A_WIDTH(CW), .B_WIDTH(FRAC_WIDTH)) u_mul_1 (
      .clock (clock),
      .en    (stage_en[ST_P1:ST_COEF+1]),
      .a     (coef_3_1),
      .b     (frac_1),
      .p     (prod_1)
   );

   // First Horner sums: value, slope (3c3, 2c2) and the finished curvature
   // numerator (6c3 * t + 2c2).
   always_comb begin
      horner_1_in = H1W'(prod_1) + (H1W'(coef_2_3) <<< FRAC_WIDTH);
      slope_1_in  = (G1W'(prod_1) <<< 1) + G1W'(prod_1)
                  + (G1W'(coef_2_3) <<< (FRAC_WIDTH + 1));
      curv_num_in = (E2W'(prod_1) <<< 2) + (E2W'(prod_1) <<< 1)
                  + (E2W'(coef_2_3) <<< (FRAC_WIDTH + 1));
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ADD1]) begin
         horner_1_ff <= horner_1_in;
         slope_1_ff  <= slope_1_in;
         curv_num_ff <= curv_num_in;
      end
   end

   // Curvature: round now, then ride along to the output stage.
   cbse_round #(
      .NUM_WIDTH (E2W),
      .SHIFT     (FRAC_WIDTH),
      .OUT_WIDTH (SAMPLE_WIDTH + 2),
      .MAG_WIDTH (MW)
   ) u_rnd_curv (
      .clock (clock),
      .en    (stage_en[ST_D2R:ST_ADD1+1]),
      .num   (curv_num_ff),
      .res   (curv_rnd)
   );

   cbse_dly #(.WIDTH(SAMPLE_WIDTH + 2), .DEPTH(ST_OUT - ST_D2R)) u_dly_curv (
      .clock (clock),
      .en    (stage_en[ST_OUT:ST_D2R+1]),
      .d     (curv_rnd),
      .q     (rsp_curvature)
   );

   // Second Horner products.
   cbse_mul #(.A_WIDTH(H1W), .B_WIDTH(FRAC_WIDTH)) u_mul_2 (
      .clock (clock),
      .en    (stage_en[ST_Q1:ST_ADD1+1]),
      .a     (horner_1_ff),
      .b     (frac_4),
      .p     (prod_2)
   );

   cbse_mul #(.A_WIDTH(G1W), .B_WIDTH(FRAC_WIDTH)) u_mul_slope (
      .clock (clock),
      .en    (stage_en[ST_Q1:ST_ADD1+1]),
      .a     (slope_1_ff),
      .b     (frac_4),
      .p     (slope_prod)
   );

   // Second Horner sums; the slope numerator is finished here.
   always_comb begin
      horner_2_in  = H2W'(prod_2) + (H2W'(coef_1_6) <<< (2 * FRAC_WIDTH));
      slope_num_in = D1W'(slope_prod) + (D1W'(coef_1_6) <<< (2 * FRAC_WIDTH));
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ADD2]) begin
         horner_2_ff  <= horner_2_in;
         slope_num_ff <= slope_num_in;
      end
   end

   // Slope: round, then delay to the output stage.
   cbse_round #(
      .NUM_WIDTH (D1W),
      .SHIFT     (2 * FRAC_WIDTH),
      .OUT_WIDTH (SAMPLE_WIDTH + 1),
      .MAG_WIDTH (MW)
   ) u_rnd_slope (
      .clock (clock),
      .en    (stage_en[ST_D1R:ST_ADD2+1]),
      .num   (slope_num_ff),
      .res   (slope_rnd)
   );

   cbse_dly #(.WIDTH(SAMPLE_WIDTH + 1), .DEPTH(ST_OUT - ST_D1R)) u_dly_slope (
      .clock (clock),
      .en    (stage_en[ST_OUT:ST_D1R+1]),
      .d     (slope_rnd),
      .q     (rsp_slope)
   );

   // Third Horner product and the finished value numerator.
   cbse_mul #(.A_WIDTH(H2W), .B_WIDTH(FRAC_WIDTH)) u_mul_3 (
      .clock (clock),
      .en    (stage_en[ST_Q2:ST_ADD2+1]),
      .a     (horner_2_ff),
      .b     (frac_7),
      .p     (prod_3)
   );

   assign value_num_in = VW'(prod_3) + (VW'(coef_0_9) <<< (3 * FRAC_WIDTH));

   always_ff @(posedge clock) begin
      if (stage_en[ST_ADD3]) begin
         value_num_ff <= value_num_in;
      end
   end

   // Value: its rounding unit ends in the response register.
   cbse_round #(
      .NUM_WIDTH (VW),
      .SHIFT     (3 * FRAC_WIDTH),
      .OUT_WIDTH (SAMPLE_WIDTH),
      .MAG_WIDTH (MW)
   ) u_rnd_value (
      .clock (clock),
      .en    (stage_en[ST_OUT:ST_ADD3+1]),
      .num   (value_num_ff),
      .res   (rsp_curve_value)
   );

   // An accepted request word always lands in the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> vld_ff[1])
      else $error("accepted request word did not enter the pipeline");

   // The request side stalls only when every stage is full and the output is held.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&vld_ff) && rsp_stall))
      else $error("request stalled while the pipeline had room");

   // Words in flight change only by accepted requests and taken responses.
   a_word_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(vld_ff) + $past(int'(out_acc))
                         == $past($countones(vld_ff)) + $past(int'(in_acc))))
      else $error("word lost or duplicated in the pipeline");

endmodule
